// File: rtl/tbq4_pkg.sv
// Shared constants, types and float helper functions for the Q4_0 block packer.
package tbq4_pkg;

    localparam int BLOCK_ELEMS = 32;
    localparam int IDX_W       = $clog2(BLOCK_ELEMS);
    localparam int HALF_ELEMS  = BLOCK_ELEMS / 2;

    localparam logic [3:0] CODE_ZERO = 4'd8;
    localparam logic [3:0] CODE_POS  = 4'd9;
    localparam logic [3:0] CODE_NEG  = 4'd7;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_TER = 2'd1;
    localparam logic [1:0] ST_INEXACT = 2'd2;

    localparam logic [31:0] F32_INF = 32'h7f80_0000;
    localparam logic [15:0] F16_INF = 16'h7c00;

    typedef logic [31:0] f32_t;
    typedef logic [15:0] f16_t;

    // Non-negative, non-NaN fp32 magnitude to fp16, round to nearest even.
    function automatic f16_t mag_to_half(input f32_t m);
        logic [7:0]  e;
        logic [22:0] f;
        logic [23:0] mant;
        logic [4:0]  s;
        logic [23:0] rem;
        logic [23:0] half;
        logic [15:0] h;
        logic [12:0] rb;
        e = m[30:23];
        f = m[22:0];
        mant = {1'b1, f};
        s = 5'd0;
        rem = '0;
        half = '0;
        h = '0;
        rb = f[12:0];
        if (e == 8'hff || e >= 8'd143) begin
            h = F16_INF;
        end
        else if (e >= 8'd113) begin
            h = {1'b0, 5'(e - 8'd112), f[22:13]};
            if (rb > 13'h1000 || (rb == 13'h1000 && h[0]))
                h = h + 16'd1;
        end
        else if (e == 8'd0 || e < 8'd102) begin
            h = '0;
        end
        else begin
            s = 5'(8'd126 - e);
            h = 16'(mant >> s);
            rem = mant & ((24'd1 << s) - 24'd1);
            half = 24'd1 << (s - 5'd1);
            if (rem > half || (rem == half && h[0]))
                h = h + 16'd1;
        end
        return h;
    endfunction

    // Non-negative fp16 pattern to fp32 pattern.
    function automatic f32_t half_to_single(input f16_t h);
        logic [4:0] e;
        logic [9:0] f;
        logic [3:0] p;
        f32_t r;
        e = h[14:10];
        f = h[9:0];
        p = 4'd0;
        r = '0;
        if (e == 5'd31) begin
            r = F32_INF | {9'd0, f, 13'd0};
        end
        else if (e == 5'd0) begin
            for (int i = 0; i < 10; i++)
                if (f[i])
                    p = 4'(i);
            if (f != 10'd0)
                r = {1'b0, 8'(8'd103 + 8'(p)), 23'({f, 13'd0} << (4'd10 - p))};
        end
        else begin
            r = {1'b0, 8'(8'd112 + 8'(e)), f, 13'd0};
        end
        return r;
    endfunction

endpackage

// File: rtl/ternary_block_to_q4_0_packer_top.sv
// Q4_0 block packer: gathers 32 fp32 elements, then scans them to emit one block.
// Steps: a scan (one setup step that checks the scale round trip, then one memory read
// per element), then an output load, which waits while an earlier output beat is held.
// Throughput: one element per cycle while gathering; input is blocked during the scan
// and the load, so a new block's elements are taken only once the current block is loaded.
// Reset (rst_n low, asynchronous): count, maximum, scan and output valid clear.
module ternary_block_to_q4_0_packer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] element_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] scale_bits,
    output logic [63:0] packed_low,
    output logic [63:0] packed_high,
    output logic [1:0]  status
);

    localparam logic [1:0] S_FILL = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // Element memory: one write port (gather), one registered read port (scan).
    logic [31:0] mem [tbq4_pkg::BLOCK_ELEMS];
    logic [31:0] rd_data_reg;

    logic [1:0]  state_reg, state_next;
    logic [tbq4_pkg::IDX_W-1:0] cnt_reg, cnt_next;       // gather count / read address
    logic [tbq4_pkg::IDX_W-1:0] sidx_reg, sidx_next;     // index of data in rd_data_reg
    logic        rd_vld_reg, rd_vld_next;
    logic [31:0] max_reg, max_next;
    logic [15:0] scale_reg, scale_next;
    logic [31:0] dbits_reg, dbits_next;
    logic [3:0]  codes_reg [tbq4_pkg::BLOCK_ELEMS];
    logic        nter_reg, nter_next;
    logic        inex_reg, inex_next;
    logic        out_valid_reg, out_valid_next;

    logic        in_fire;
    logic [30:0] in_mag;
    logic [30:0] vm;
    logic [3:0]  code_cur;
    logic        chk_inex;

    assign in_ready = (state_reg == S_FILL);
    assign in_fire  = in_valid && in_ready;
    assign in_mag   = element_bits[30:0];
    assign vm       = rd_data_reg[30:0];

    always_ff @(posedge clk)
    begin
        if (in_fire)
            mem[cnt_reg] <= element_bits;
        rd_data_reg <= mem[cnt_reg];
    end

    // Code and round-trip check of the element currently read out.
    always_comb
    begin
        chk_inex = 1'b0;
        if (vm > 31'h7f80_0000 || vm == 31'd0) begin
            code_cur = tbq4_pkg::CODE_ZERO;
            chk_inex = (rd_data_reg != 32'd0) || (dbits_reg == tbq4_pkg::F32_INF);
        end
        else if (rd_data_reg[31]) begin
            code_cur = tbq4_pkg::CODE_NEG;
            chk_inex = rd_data_reg != (dbits_reg | 32'h8000_0000);
        end
        else begin
            code_cur = tbq4_pkg::CODE_POS;
            chk_inex = rd_data_reg != dbits_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sidx_next      = sidx_reg;
        rd_vld_next    = 1'b0;
        max_next       = max_reg;
        scale_next     = scale_reg;
        dbits_next     = dbits_reg;
        nter_next      = nter_reg;
        inex_next      = inex_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_FILL:
            begin
                if (in_fire) begin
                    if (in_mag <= 31'h7f80_0000 && {1'b0, in_mag} > max_reg)
                        max_next = {1'b0, in_mag};
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == tbq4_pkg::IDX_W'(tbq4_pkg::BLOCK_ELEMS - 1)) begin
                        state_next = S_SCAN;
                        scale_next = tbq4_pkg::mag_to_half(max_next);
                        nter_next  = 1'b0;
                        inex_next  = 1'b0;
                    end
                end
            end
            S_SCAN:
            begin
                if (rd_vld_reg) begin
                    if (vm != 31'd0 && {1'b0, vm} != max_reg)
                        nter_next = 1'b1;
                    if (chk_inex)
                        inex_next = 1'b1;
                end
                else begin
                    // first scan cycle: round-trip of scale
                    dbits_next = tbq4_pkg::half_to_single(scale_reg);
                    inex_next  = dbits_next != max_reg;
                end
                if (rd_vld_reg && sidx_reg == tbq4_pkg::IDX_W'(tbq4_pkg::BLOCK_ELEMS - 1)) begin
                    state_next = S_DONE;
                end
                else begin
                    rd_vld_next = 1'b1;
                    sidx_next   = cnt_reg;
                    cnt_next    = cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next = 1'b1;
                    state_next     = S_FILL;
                    cnt_next       = '0;
                    max_next       = '0;
                end
            end
            default:
            begin
                state_next = S_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_FILL;
            cnt_reg       <= '0;
            sidx_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
            nter_reg      <= 1'b0;
            inex_reg      <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sidx_reg      <= sidx_next;
            rd_vld_reg    <= rd_vld_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
            nter_reg      <= nter_next;
            inex_reg      <= inex_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scale_reg <= scale_next;
        dbits_reg <= dbits_next;
        if (state_reg == S_SCAN && rd_vld_reg)
            codes_reg[sidx_reg] <= code_cur;
    end

    // Output holding register, loaded after the scan once no earlier output beat is held.
    logic [15:0] o_scale_reg;
    logic [63:0] o_lo_reg, o_hi_reg;
    logic [1:0]  o_st_reg;
    logic [63:0] lo_w, hi_w;

    always_comb
    begin
        for (int j = 0; j < 8; j++) begin
            lo_w[8*j +: 8] = {codes_reg[j + tbq4_pkg::HALF_ELEMS], codes_reg[j]};
            hi_w[8*j +: 8] = {codes_reg[j + 8 + tbq4_pkg::HALF_ELEMS], codes_reg[j + 8]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && (!out_valid_reg || out_ready)) begin
            o_scale_reg <= scale_reg;
            o_lo_reg    <= lo_w;
            o_hi_reg    <= hi_w;
            o_st_reg    <= nter_reg ? tbq4_pkg::ST_NOT_TER :
                           (inex_reg ? tbq4_pkg::ST_INEXACT : tbq4_pkg::ST_OK);
        end
    end

    assign out_valid   = out_valid_reg;
    assign scale_bits  = o_scale_reg;
    assign packed_low  = o_lo_reg;
    assign packed_high = o_hi_reg;
    assign status      = o_st_reg;

endmodule

// File: rtl/tbq4_checker.sv
// Port-level checker for the Q4_0 block packer, bound to the top level.
module tbq4_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] scale_bits,
    input logic [1:0]  status
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input beat withdrawn while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(scale_bits) && $stable(status))
        else $error("output beat changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("status code out of range");

    a_new_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("block emitted while gathering");

endmodule

bind ternary_block_to_q4_0_packer_top tbq4_checker u_tbq4_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .scale_bits(scale_bits), .status(status)
);
